// ===== rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// shared constants and types of the bitmap frame allocator: bitmap geometry,
// operation and status codes, transaction structs and the memory access bundle
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAME_COUNT = 4096;
  localparam int WORD_BITS   = 32;
  localparam int WORD_TOTAL  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W       = $clog2(WORD_BITS);
  localparam int ADDR_W      = $clog2(WORD_TOTAL);
  localparam int FRAME_W     = 12;
  localparam int LIMIT_W     = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(FRAME_COUNT);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(FRAME_COUNT);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_CHANGE = 2'd1;
  localparam logic [1:0] ST_NO_FRAMES = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [FRAME_W-1:0] page_frame;
    logic               kernel_page;
    logic               write_enable;
  } bfa_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] new_frame;
    logic               present;
    logic               writable;
    logic               user_access;
    logic [1:0]         status;
  } bfa_result_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } bfa_mem_req_t;

endpackage

// ===== rtl/bfa_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_bitmap_ram
// frame bitmap storage: one write port, one read port with registered data;
// per-word valid bits make every word read as zero after reset
// ----------------------------------------------------------------------------
module bfa_bitmap_ram (
  input  logic                           clk,
  input  logic                           rst,
  input  bfa_pkg::bfa_mem_req_t          mem_req,
  output logic [bfa_pkg::WORD_BITS-1:0]  rd_data
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0]  mem [WORD_TOTAL];
  logic [WORD_TOTAL-1:0] valid;
  logic [WORD_BITS-1:0]  rd_word;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_word <= mem[mem_req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (mem_req.wr_en) begin
        valid[mem_req.wr_addr] <= 1'b1;
      end
      if (mem_req.rd_en) begin
        rd_valid <= valid[mem_req.rd_addr];
      end
    end
  end

  // a word never written since reset holds only free frames
  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// ===== rtl/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// request sequencer: scans bitmap words one per cycle for the lowest free
// frame, and does read-modify-write of a single word for allocate and free
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  bfa_pkg::bfa_req_t             req,
  output logic                          busy,
  input  logic [bfa_pkg::LIMIT_W-1:0]   frame_limit,
  output bfa_pkg::bfa_mem_req_t         mem_req,
  input  logic [bfa_pkg::WORD_BITS-1:0] rd_data,
  output logic                          done,
  output bfa_pkg::bfa_result_t          result
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FREE = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] chk_ptr, chk_ptr_next;
  logic [ADDR_W-1:0] last_word, last_word_next;
  logic [IDX_W-1:0]  last_bit, last_bit_next;
  bfa_req_t          req_q, req_q_next;
  logic              done_next;
  bfa_result_t       result_next;

  logic [LIMIT_W-1:0]   lim_eff;
  logic [FRAME_W-1:0]   lim_m1;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  logic [WORD_BITS-1:0] found_onehot;
  logic [WORD_BITS-1:0] clear_onehot;

  assign lim_eff = (frame_limit > LIMIT_MAX) ? LIMIT_MAX : frame_limit;
  assign lim_m1  = FRAME_W'(lim_eff - LIMIT_W'(1));

  // frames of the current word that lie in [1, limit)
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      scan_mask[b] = ((chk_ptr != last_word) || (IDX_W'(b) <= last_bit)) &&
                     !((chk_ptr == '0) && (b == 0));
    end
  end

  assign free_bits = ~rd_data & scan_mask;
  assign found     = |free_bits;

  // lowest free bit wins
  always_comb begin
    found_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found_idx = IDX_W'(b);
      end
    end
  end

  assign found_onehot = WORD_BITS'(1) << found_idx;
  assign clear_onehot = WORD_BITS'(1) << req_q.page_frame[IDX_W-1:0];

  always_comb begin
    state_next     = state;
    chk_ptr_next   = chk_ptr;
    last_word_next = last_word;
    last_bit_next  = last_bit;
    req_q_next     = req_q;
    done_next      = 1'b0;
    result_next    = result;
    mem_req        = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_q_next     = req;
          last_word_next = lim_m1[FRAME_W-1:IDX_W];
          last_bit_next  = lim_m1[IDX_W-1:0];
          if (req.mode == MODE_ALLOC) begin
            if (req.page_frame != '0) begin
              done_next   = 1'b1;
              result_next = '{req.page_frame, 1'b0, 1'b0, 1'b0, ST_NO_CHANGE};
            end else if (lim_eff <= LIMIT_W'(1)) begin
              done_next   = 1'b1;
              result_next = '{'0, 1'b0, 1'b0, 1'b0, ST_NO_FRAMES};
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = '0;
              chk_ptr_next    = '0;
              state_next      = S_SCAN;
            end
          end else begin
            if (req.page_frame == '0) begin
              done_next   = 1'b1;
              result_next = '{'0, 1'b0, 1'b0, 1'b0, ST_NO_CHANGE};
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = req.page_frame[FRAME_W-1:IDX_W];
              state_next      = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = chk_ptr;
          mem_req.wr_data = rd_data | found_onehot;
          done_next       = 1'b1;
          result_next     = '{{chk_ptr, found_idx}, 1'b1, req_q.write_enable,
                              !req_q.kernel_page, ST_DONE};
          state_next      = S_IDLE;
        end else if (chk_ptr == last_word) begin
          done_next   = 1'b1;
          result_next = '{'0, 1'b0, 1'b0, 1'b0, ST_NO_FRAMES};
          state_next  = S_IDLE;
        end else begin
          // data for the next word arrives with the next cycle
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = chk_ptr + ADDR_W'(1);
          chk_ptr_next    = chk_ptr + ADDR_W'(1);
        end
      end
      S_FREE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = req_q.page_frame[FRAME_W-1:IDX_W];
        mem_req.wr_data = rd_data & ~clear_onehot;
        done_next       = 1'b1;
        result_next     = '{'0, 1'b0, 1'b0, 1'b0, ST_DONE};
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_ptr   <= chk_ptr_next;
    last_word <= last_word_next;
    last_bit  <= last_bit_next;
    req_q     <= req_q_next;
    result    <= result_next;
  end

  assign busy = (state != S_IDLE);

  // results only appear once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // bitmap is written only in the final cycle of an item
  a_write_final: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |=> done)
    else $error("bitmap write without result");

  // the scan never walks past the last word in range
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (chk_ptr <= last_word))
    else $error("scan beyond limit");

  // a handed-out frame is never frame zero
  a_no_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.present) |-> (result.new_frame != '0))
    else $error("frame zero allocated");

endmodule

// ===== rtl/bitmap_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// physical frame allocator over a bitmap with one bit per frame
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result is shown on
// result for exactly one cycle with done high; the receiver cannot stall it.
// Allocate with a frame already held, free of frame zero, and allocate with
// frame_limit at or below one finish without a bitmap access. A free reads
// one bitmap word and then writes it back. An allocate scan reads one 32-bit
// bitmap word per cycle through the single read port of the bitmap memory,
// visiting words up to the first word holding a free frame, at most 128 for
// 4096 frames. The bitmap is free right after reset with no clearing pass.
// frame_limit is written on the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  bfa_pkg::bfa_req_t            req,
  output logic                         busy,
  output logic                         done,
  output bfa_pkg::bfa_result_t         result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfa_pkg::LIMIT_W-1:0]  cfg_data
);
  import bfa_pkg::*;

  logic [LIMIT_W-1:0]   frame_limit;
  bfa_mem_req_t         mem_req;
  logic [WORD_BITS-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_limit <= cfg_data;
    end
  end

  bfa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req),
    .busy        (busy),
    .frame_limit (frame_limit),
    .mem_req     (mem_req),
    .rd_data     (rd_data),
    .done        (done),
    .result      (result)
  );

  bfa_bitmap_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule
